@@ src/c_escape_sequence_decoder_core_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the escape sequence decoder
// Concurrent assertion wrappers, clocked on clk and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef C_ESCAPE_SEQUENCE_DECODER_CORE_MACROS_SVH
`define C_ESCAPE_SEQUENCE_DECODER_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define CESD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define CESD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define CESD_ASSERT_NOW(label, ante, cons, msg)

`define CESD_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

@@ src/cesd_pkg.sv @@
// ----------------------------------------------------------------------------
// cesd_pkg
// Types, character constants and lookup functions of the escape decoder.
// ----------------------------------------------------------------------------
package cesd_pkg;

	localparam int unsigned MAX_RESULTS = 5;
	localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

	localparam logic [7:0] CH_BSLASH  = 8'h5C;
	localparam logic [7:0] CH_X       = 8'h78;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_F = 8'h66;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_F = 8'h46;
	localparam logic [7:0] CH_HEX_TEN = 8'd10;
	localparam logic [7:0] CH_NUL     = 8'h00;

	typedef enum logic [3:0] {
		MODE_NORMAL = 4'b0001,
		MODE_ESC    = 4'b0010,
		MODE_HEX1   = 4'b0100,
		MODE_HEX2   = 4'b1000
	} mode_t;

	typedef struct packed {
		mode_t      mode;
		logic [7:0] held;
	} cesd_state_t;

	typedef struct packed {
		logic [CNT_W-1:0]            count;
		logic [MAX_RESULTS-1:0][7:0] bytes;
	} cesd_list_t;

	typedef struct packed {
		logic       emit;
		logic [7:0] val;
		mode_t      mode;
	} cesd_step_t;

	function automatic cesd_list_t push(cesd_list_t l, logic [7:0] v);
		cesd_list_t r;
		r = l;
		r.bytes[l.count] = v;
		r.count = CNT_W'(l.count + 1'b1);
		return r;
	endfunction

	// Returns the hit flag above the decoded value.
	function automatic logic [8:0] simple_escape(logic [7:0] c);
		logic [8:0] r;
		unique case (c)
			8'h61:   r = {1'b1, 8'd7};
			8'h62:   r = {1'b1, 8'd8};
			8'h66:   r = {1'b1, 8'd12};
			8'h6E:   r = {1'b1, 8'd10};
			8'h72:   r = {1'b1, 8'd13};
			8'h74:   r = {1'b1, 8'd9};
			8'h76:   r = {1'b1, 8'd11};
			8'h5C:   r = {1'b1, 8'd92};
			8'h3F:   r = {1'b1, 8'd63};
			8'h27:   r = {1'b1, 8'd39};
			8'h22:   r = {1'b1, 8'd34};
			8'h30:   r = {1'b1, 8'd0};
			default: r = {1'b0, c};
		endcase
		return r;
	endfunction

	// Returns the valid flag above the nibble value.
	function automatic logic [4:0] hex_value(logic [7:0] c);
		logic [4:0] r;
		r = '0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			r = {1'b1, 4'(c - CH_ZERO)};
		end else if (c >= CH_LOWER_A && c <= CH_LOWER_F) begin
			r = {1'b1, 4'(c - CH_LOWER_A + CH_HEX_TEN)};
		end else if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
			r = {1'b1, 4'(c - CH_UPPER_A + CH_HEX_TEN)};
		end
		return r;
	endfunction

	// One byte handled from the normal or the after-backslash mode.
	function automatic cesd_step_t step_plain(logic esc, logic [7:0] b);
		cesd_step_t r;
		logic [8:0] se;
		se     = simple_escape(b);
		r.emit = 1'b0;
		r.val  = b;
		r.mode = MODE_NORMAL;
		if (!esc) begin
			if (b == CH_BSLASH) begin
				r.mode = MODE_ESC;
			end else begin
				r.emit = 1'b1;
			end
		end else if (se[8]) begin
			r.emit = 1'b1;
			r.val  = se[7:0];
		end else if (b == CH_X) begin
			r.mode = MODE_HEX1;
		end else begin
			r.emit = 1'b1;
		end
		return r;
	endfunction

endpackage

@@ src/cesd_decode.sv @@
// ----------------------------------------------------------------------------
// cesd_decode
// Builds the full list of result bytes for one input byte and the next state.
// ----------------------------------------------------------------------------
module cesd_decode (
	input  cesd_pkg::cesd_state_t cur,
	input  logic [7:0]            in_byte,
	input  logic                  in_last,
	output cesd_pkg::cesd_list_t  lst,
	output cesd_pkg::cesd_state_t nxt
);
	import cesd_pkg::*;

	cesd_step_t r1;
	cesd_step_t r2;
	cesd_step_t r3;
	logic [4:0] hi;
	logic [4:0] lo;

	always_comb begin
		lst = '0;
		nxt = cur;
		r1  = '0;
		r2  = '0;
		r3  = '0;
		hi  = hex_value(cur.held);
		lo  = hex_value(in_byte);
		unique case (cur.mode) inside
			MODE_NORMAL, MODE_ESC: begin
				r1 = step_plain(cur.mode == MODE_ESC, in_byte);
				if (r1.emit) begin
					lst = push(lst, r1.val);
				end
				nxt.mode = r1.mode;
			end
			MODE_HEX1: begin
				nxt.held = in_byte;
				nxt.mode = MODE_HEX2;
			end
			MODE_HEX2: begin
				nxt.held = '0;
				if (hi[4] && lo[4]) begin
					lst      = push(lst, {hi[3:0], lo[3:0]});
					nxt.mode = MODE_NORMAL;
				end else begin
					lst = push(lst, CH_BSLASH);
					lst = push(lst, CH_X);
					r1  = step_plain(1'b0, cur.held);
					if (r1.emit) begin
						lst = push(lst, r1.val);
					end
					r2 = step_plain(r1.mode == MODE_ESC, in_byte);
					if (r2.emit) begin
						lst = push(lst, r2.val);
					end
					nxt.mode = r2.mode;
				end
			end
			default: begin
				nxt.mode = MODE_NORMAL;
				nxt.held = '0;
			end
		endcase
		if (in_last) begin
			if (nxt.mode == MODE_HEX1) begin
				lst = push(lst, CH_X);
			end else if (nxt.mode == MODE_HEX2) begin
				lst = push(lst, CH_X);
				r3  = step_plain(1'b0, nxt.held);
				if (r3.emit) begin
					lst = push(lst, r3.val);
				end
			end
			nxt.mode = MODE_NORMAL;
			nxt.held = '0;
			lst      = push(lst, CH_NUL);
		end
	end

endmodule

@@ src/c_escape_sequence_decoder_core.sv @@
// ----------------------------------------------------------------------------
// c_escape_sequence_decoder_core
// Decodes C escape sequences in a byte stream of string literal contents.
// ----------------------------------------------------------------------------
// The input channel carries one raw byte per request with a flag on the final
// byte of a literal; the output channel carries decoded bytes, a flag on the
// last result of each input request and a flag on the appended terminator.
// An accepted byte sits in the input register, from which its results move
// one at a time into the output register. A byte that yields no result
// retires at once, and a byte that yields one result retires as the output
// register takes it, so such bytes flow at one per cycle while the receiver
// does not stall. A byte that yields several results holds the input register
// until its last result is taken, as the output register takes one result
// each cycle while free; at most five results come from one byte.
// A new byte is taken whenever the input register is empty or retires in that
// cycle, even while the output register still waits for the receiver.
// When the receiver stalls, the output register holds its result and the
// input register holds any byte that has results, and the input channel then stops taking.
// Reset empties both registers and returns the decoder to its normal mode.
// ----------------------------------------------------------------------------
`include "c_escape_sequence_decoder_core_macros.svh"

module c_escape_sequence_decoder_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       run_end,
	output logic       is_terminator
);
	import cesd_pkg::*;

	logic             s1_valid_q;
	logic [7:0]       byte_s1;
	logic             last_s1;
	logic [CNT_W-1:0] idx_q;
	cesd_state_t      state_q;
	cesd_state_t      state_nxt;
	cesd_list_t       lst;
	logic             out_valid_q;
	logic [7:0]       out_byte_q;
	logic             run_end_q;
	logic             is_term_q;
	logic             out_free;
	logic             at_final;
	logic             emit;
	logic             item_done;

	cesd_decode u_decode (
		.cur     (state_q),
		.in_byte (byte_s1),
		.in_last (last_s1),
		.lst     (lst),
		.nxt     (state_nxt)
	);

	assign out_free  = !out_valid_q || out_ready;
	assign at_final  = idx_q == CNT_W'(lst.count - 1'b1);
	assign emit      = s1_valid_q && (lst.count != '0) && out_free;
	assign item_done = s1_valid_q && ((lst.count == '0) || (out_free && at_final));
	assign in_ready  = !s1_valid_q || item_done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q   <= 1'b0;
			idx_q        <= '0;
			state_q.mode <= MODE_NORMAL;
			state_q.held <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				s1_valid_q <= 1'b1;
			end else if (item_done) begin
				s1_valid_q <= 1'b0;
			end
			if (item_done) begin
				state_q <= state_nxt;
			end
			if (emit) begin
				idx_q       <= at_final ? '0 : CNT_W'(idx_q + 1'b1);
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
			last_s1 <= in_last;
		end
		if (emit) begin
			out_byte_q <= lst.bytes[idx_q];
			run_end_q  <= at_final;
			is_term_q  <= at_final && last_s1;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_byte      = out_byte_q;
	assign run_end       = run_end_q;
	assign is_terminator = is_term_q;

	`CESD_ASSERT_NOW(a_idx_in_list, s1_valid_q && (lst.count != '0), idx_q < lst.count, "result index beyond list")
	`CESD_ASSERT_NOW(a_idx_idle, !s1_valid_q, idx_q == '0, "result index not cleared")
	`CESD_ASSERT_NOW(a_term_ends_run, out_valid_q && is_term_q, run_end_q, "terminator not last of run")
	`CESD_ASSERT_NEXT(a_literal_reset, item_done && last_s1, (state_q.mode == MODE_NORMAL) && (state_q.held == '0), "state not cleared after literal")
	`CESD_ASSERT_NEXT(a_multi_holds, s1_valid_q && !item_done, s1_valid_q && $stable(byte_s1), "input register lost its byte")

endmodule
